/* design/double_ended_queue_core_macros.svh */
// Assertion shorthands used by the deque controller.
// They expect signals named aclk and aresetn in the module that uses them.
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define DEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define DEQ_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

/* design/deq_pkg.sv */
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_REAR  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_LIST       = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    // Memory port strobes.
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

    // Tells the output stage to capture a result beat.
    typedef struct packed {
        logic    load;
        logic    from_mem;
        status_t status;
        logic    last;
    } out_ctl_t;

endpackage

/* design/deq_ram.sv */
`timescale 1ns / 1ps

module deq_ram
    import deq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              aclk,
    input  mem_ctl_t          ctl,
    input  logic [AW-1:0]     addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem_array[addr] <= wdata;
        end
        // Read data holds until the next read strobe.
        if (ctl.re) begin
            rdata_reg <= mem_array[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/deq_ctrl.sv */
`timescale 1ns / 1ps

module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  cmd_t          cmd,
    input  logic          out_free,
    output logic          s_ready,
    output mem_ctl_t      mem_ctl,
    output logic [AW-1:0] mem_addr,
    output out_ctl_t      out_ctl
);

`include "double_ended_queue_core_macros.svh"

    state_t        state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          list_reg, list_next;

    logic          accept;
    logic          full;
    logic          empty;
    logic [CW-1:0] occ_dec;
    logic [AW-1:0] tail_addr;
    logic [AW-1:0] rear_addr;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] rd_addr_inc;
    logic          beat_last;

    // Ring index arithmetic: base plus offset, wrapped once into 0..DEPTH-1.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign full        = (occ_reg == CW'(DEPTH));
    assign empty       = (occ_reg == '0);
    assign occ_dec     = occ_reg - 1'b1;
    assign tail_addr   = ring_add(head_reg, occ_reg);
    assign rear_addr   = ring_add(head_reg, occ_dec);
    assign head_inc    = ring_add(head_reg, CW'(1));
    assign head_dec    = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign rd_addr_inc = ring_add(rd_addr_reg, CW'(1));
    assign beat_last   = !list_reg || (idx_reg == occ_dec);

    assign s_ready = (state_reg == S_IDLE) && out_free;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
        end
        rd_addr_reg <= rd_addr_next;
        idx_reg     <= idx_next;
        list_reg    <= list_next;
    end

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        occ_next         = occ_reg;
        rd_addr_next     = rd_addr_reg;
        idx_next         = idx_reg;
        list_next        = list_reg;
        mem_ctl          = '0;
        mem_addr         = head_reg;
        out_ctl.load     = 1'b0;
        out_ctl.from_mem = 1'b0;
        out_ctl.status   = ST_OK;
        out_ctl.last     = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
                            out_ctl.load = 1'b1;
                            if (full) begin
                                out_ctl.status = ST_FULL;
                            end else begin
                                mem_ctl.we = 1'b1;
                                occ_next   = occ_reg + 1'b1;
                                if (cmd == CMD_PUSH_REAR) begin
                                    mem_addr = tail_addr;
                                end else begin
                                    mem_addr  = head_dec;
                                    head_next = head_dec;
                                end
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_REAR, CMD_LIST: begin
                            if (empty) begin
                                out_ctl.load   = 1'b1;
                                out_ctl.status = ST_EMPTY;
                            end else begin
                                mem_ctl.re   = 1'b1;
                                state_next   = S_READ;
                                idx_next     = '0;
                                list_next    = (cmd == CMD_LIST);
                                rd_addr_next = head_reg;
                                if (cmd == CMD_POP_FRONT) begin
                                    head_next = head_inc;
                                    occ_next  = occ_dec;
                                end else if (cmd == CMD_POP_REAR) begin
                                    mem_addr = rear_addr;
                                    occ_next = occ_dec;
                                end
                            end
                        end
                        default: begin
                            // Unused command codes are consumed silently.
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    out_ctl.load     = 1'b1;
                    out_ctl.from_mem = 1'b1;
                    out_ctl.last     = beat_last;
                    if (beat_last) begin
                        state_next = S_IDLE;
                    end else begin
                        mem_ctl.re   = 1'b1;
                        mem_addr     = rd_addr_inc;
                        rd_addr_next = rd_addr_inc;
                        idx_next     = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `DEQ_NEVER(a_occ_range, occ_reg > CW'(DEPTH), "occupancy beyond capacity")
    `DEQ_NEVER(a_head_range, (AW+1)'(head_reg) >= (AW+1)'(DEPTH), "head pointer out of range")
    `DEQ_NEVER(a_no_write_in_read, (state_reg == S_READ) && mem_ctl.we, "write during read phase")
    `DEQ_ASSERT(a_push_grows, (accept && !full && (cmd == CMD_PUSH_REAR || cmd == CMD_PUSH_FRONT)) |=> (occ_reg == $past(occ_reg) + 1'b1), "push did not grow occupancy")
    `DEQ_ASSERT(a_list_frozen, (state_reg == S_READ) |=> (head_reg == $past(head_reg)), "head moved during read phase")

endmodule

/* design/double_ended_queue_core.sv */
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit values held in a ring buffer of DEPTH
// entries. Each input beat is one command in s_tuser: push at the rear, push
// at the front, pop from the front, pop from the rear, or list the contents.
// Each push or pop yields one result beat with m_tlast set; list yields one
// beat per stored element from front to rear with m_tlast on the rear one
// (or a single empty-status beat when nothing is stored). Codes 5 to 7 are
// accepted and ignored, with no result beat. A push is answered in the cycle
// after it is taken, so pushes run at one command per cycle while m_tready
// keeps the output free. A pop or a non-empty list first reads the storage
// memory (single-port) into its read register, and a list then yields one
// element per cycle while the output is free. Commands are taken only while
// no read is in flight and the output register is free or being emptied. A
// push into a full queue leaves it unchanged and reports full status; a pop
// on an empty queue reports underflow. Storage is not cleared at reset: only
// live entries are read.
module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // [31:0] value
    input  logic [CMD_W-1:0]    s_tuser,   // [2:0] cmd

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,   // [31:0] value_res
    output logic [STATUS_W-1:0] m_tuser,   // [1:0] status
    output logic                m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mem_ctl_t          mem_ctl;
    logic [AW-1:0]     mem_addr;
    logic [DATA_W-1:0] mem_rdata;
    out_ctl_t          out_ctl;
    logic              out_free;

    // The result beat lives in a single output register. It may be refilled
    // in the same cycle in which the sink takes the beat it holds.
    logic                m_tvalid_reg;
    logic [DATA_W-1:0]   m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;
    logic                m_tlast_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    deq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .cmd      (cmd_t'(s_tuser)),
        .out_free (out_free),
        .s_ready  (s_tready),
        .mem_ctl  (mem_ctl),
        .mem_addr (mem_addr),
        .out_ctl  (out_ctl)
    );

    // Pushed values go straight from the input beat into the memory.
    deq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (s_tdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_ctl.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        // Status beats and push acknowledgements carry a zero value.
        if (out_ctl.load) begin
            m_tdata_reg <= out_ctl.from_mem ? mem_rdata : '0;
            m_tuser_reg <= out_ctl.status;
            m_tlast_reg <= out_ctl.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
